### hdl/ttcm_pkg.sv
package ttcm_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int MAX_LEVELS      = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHECK_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEVEL_MASK   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEVEL_BASE   = 3'd2;

   localparam logic signed [15:0] NO_LEVEL  = -16'sd9999;
   localparam logic        [1:0]  COUNT_MAX = 2'd2;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               read_ok;
   } ttcm_req_type;

   typedef struct packed {
      logic               notify;
      logic signed [15:0] current_temp;
      logic signed [15:0] crossed_level;
      logic               crossed_down;
      logic               comm_fault;
   } ttcm_rsp_type;

   typedef struct packed {
      logic                  check_enable;
      logic [MAX_LEVELS-1:0] level_mask;
   } ttcm_ctrl_type;

endpackage

### hdl/temp_threshold_crossing_monitor.sv
// Temperature threshold crossing monitor. Each request is one sensor poll (sample and read_ok);
// each yields exactly one response carrying the stored temperature, the last threshold crossed
// (-9999 until one is seen), its direction, the poll's communication fault and a notify flag set
// when the crossing or the fault status changed. A taken request enters one input register;
// once the response register is free or being read, a single pass of parallel threshold
// compares updates the state and loads the response register. A new request is taken every
// cycle while the response side keeps up. The user must write registers through the csr port
// only while no request is in flight; the block does not enforce it. Indexes 0 and 1 hold
// check_enable and the level mask, 2 onwards the high/low threshold pairs.
module temp_threshold_crossing_monitor #(
   parameter int NUM_LEVELS = 3
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ttcm_pkg::ttcm_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ttcm_pkg::ttcm_rsp_type               rsp_data,
   input  logic                                 csr_write_en,
   input  logic [ttcm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ttcm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import ttcm_pkg::*;

   ttcm_ctrl_type      ctrl;
   logic signed [15:0] high_level [NUM_LEVELS];
   logic signed [15:0] low_level  [NUM_LEVELS];

   logic               s1_valid_ff, s1_valid_in;
   ttcm_req_type       s1_req_ff;
   logic               core_ready;

   assign req_ready   = !s1_valid_ff || core_ready;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_req_ff <= req_data;
      end
   end

   ttcm_csr #(
      .NUM_LEVELS(NUM_LEVELS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .ctrl         (ctrl),
      .high_level   (high_level),
      .low_level    (low_level)
   );

   ttcm_core #(
      .NUM_LEVELS(NUM_LEVELS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_ready   (core_ready),
      .in_req     (s1_req_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .ctrl       (ctrl),
      .high_level (high_level),
      .low_level  (low_level)
   );

endmodule

### hdl/ttcm_csr.sv
module ttcm_csr #(
   parameter int NUM_LEVELS = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [ttcm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ttcm_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output ttcm_pkg::ttcm_ctrl_type                ctrl,
   output logic signed [15:0]                     high_level [NUM_LEVELS],
   output logic signed [15:0]                     low_level  [NUM_LEVELS]
);
   import ttcm_pkg::*;

   ttcm_ctrl_type ctrl_ff, ctrl_in;

   always_comb begin
      ctrl_in = ctrl_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_CHECK_ENABLE: ctrl_in.check_enable = csr_wdata[0];
            CSR_LEVEL_MASK:   ctrl_in.level_mask   = csr_wdata[MAX_LEVELS-1:0];
            default:          ctrl_in              = ctrl_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   assign ctrl = ctrl_ff;

   for (genvar i = 0; i < NUM_LEVELS; i++) begin : g_level
      localparam logic [CSR_INDEX_WIDTH-1:0] HighIdx = CSR_LEVEL_BASE + CSR_INDEX_WIDTH'(2 * i);
      localparam logic [CSR_INDEX_WIDTH-1:0] LowIdx  = HighIdx + CSR_INDEX_WIDTH'(1);

      logic signed [15:0] high_ff, high_in;
      logic signed [15:0] low_ff, low_in;

      always_comb begin
         high_in = high_ff;
         low_in  = low_ff;
         if (csr_write_en && csr_index == HighIdx) begin
            high_in = csr_wdata;
         end
         if (csr_write_en && csr_index == LowIdx) begin
            low_in = csr_wdata;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            high_ff <= '0;
            low_ff  <= '0;
         end else begin
            high_ff <= high_in;
            low_ff  <= low_in;
         end
      end

      assign high_level[i] = high_ff;
      assign low_level[i]  = low_ff;
   end

endmodule

### hdl/ttcm_core.sv
module ttcm_core #(
   parameter int NUM_LEVELS = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  ttcm_pkg::ttcm_req_type  in_req,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ttcm_pkg::ttcm_rsp_type  rsp_data,
   input  ttcm_pkg::ttcm_ctrl_type ctrl,
   input  logic signed [15:0]      high_level [NUM_LEVELS],
   input  logic signed [15:0]      low_level  [NUM_LEVELS]
);
   import ttcm_pkg::*;

   logic signed [15:0] cur_ff, cur_in;
   logic        [1:0]  count_ff, count_in;
   logic signed [15:0] level_ff, level_in;
   logic               down_ff, down_in;
   logic               fault_ff, fault_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ttcm_rsp_type       rsp_ff, rsp_in;

   logic               advance;
   logic               first;
   logic               steady;
   logic               up_found, down_found;
   logic signed [15:0] up_level, down_level;
   logic               changed;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign advance  = in_valid && in_ready;

   always_comb begin
      first      = (count_ff == 2'd0);
      steady     = (count_ff != 2'd0) && (in_req.sample == cur_ff);
      up_found   = 1'b0;
      down_found = 1'b0;
      up_level   = NO_LEVEL;
      down_level = NO_LEVEL;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (ctrl.level_mask[i]) begin
            if (in_req.sample >= high_level[i] && (first || high_level[i] > cur_ff) &&
                (!up_found || high_level[i] > up_level)) begin
               up_level = high_level[i];
               up_found = 1'b1;
            end
            if (!first && in_req.sample < low_level[i] && low_level[i] <= cur_ff &&
                (!down_found || low_level[i] < down_level)) begin
               down_level = low_level[i];
               down_found = 1'b1;
            end
         end
      end
   end

   always_comb begin
      cur_in   = cur_ff;
      count_in = count_ff;
      level_in = level_ff;
      down_in  = down_ff;
      fault_in = fault_ff;
      changed  = 1'b0;
      if (in_req.read_ok) begin
         cur_in   = in_req.sample;
         count_in = (count_ff < COUNT_MAX) ? count_ff + 2'd1 : COUNT_MAX;
         if (ctrl.check_enable && !steady) begin
            if (up_found) begin
               level_in = up_level;
               down_in  = 1'b0;
            end else if (down_found) begin
               level_in = down_level;
               down_in  = 1'b1;
            end
         end
         changed = (level_in != level_ff) || (down_in != down_ff);
      end
      fault_in = !in_req.read_ok;

      rsp_in.notify        = changed || (fault_in != fault_ff);
      rsp_in.current_temp  = cur_in;
      rsp_in.crossed_level = level_in;
      rsp_in.crossed_down  = down_in;
      rsp_in.comm_fault    = fault_in;

      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         count_ff     <= '0;
         level_ff     <= NO_LEVEL;
         down_ff      <= 1'b0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            cur_ff   <= cur_in;
            count_ff <= count_in;
            level_ff <= level_in;
            down_ff  <= down_in;
            fault_ff <= fault_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fault_holds_state: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_req.read_ok) |=>
         ($stable(cur_ff) && $stable(level_ff) && $stable(down_ff) && $stable(count_ff)))
      else $error("failed read altered stored samples or crossing state");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("accepted request produced no result");

   a_good_read_counts: assert property (@(posedge clock) disable iff (reset)
      (advance && in_req.read_ok) |=> (count_ff != 2'd0 && count_ff != 2'd3))
      else $error("sample count out of range after good read");

   a_disabled_keeps_level: assert property (@(posedge clock) disable iff (reset)
      (advance && !ctrl.check_enable) |=> ($stable(level_ff) && $stable(down_ff)))
      else $error("crossing state changed with checks disabled");

endmodule
